>>> rtl/core/uint256_divider_defines.svh
// Assertion macros for the 256-bit divider.
`ifndef UINT256_DIVIDER_DEFINES_SVH
`define UINT256_DIVIDER_DEFINES_SVH

`ifndef SYNTHESIS
`define UDIV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UDIV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UDIV_ASSERT_SAME(lbl, ante, cons, msg)
`define UDIV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/udiv_pkg.sv
// Shared constants and controller/datapath interface types for the divider.
`default_nettype none

package udiv_pkg;

    localparam int NUM_BITS = 256;
    localparam int LIMB_W   = 64;
    localparam int CNT_W    = $clog2(NUM_BITS);

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } udiv_cmd_t;

    typedef struct packed {
        logic dbz;
    } udiv_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/udiv_datapath.sv
// Shift-and-subtract datapath: operand, partial remainder and result registers.
`default_nettype none

module udiv_datapath (
    input  wire logic                        clk,
    input  wire logic [udiv_pkg::NUM_BITS-1:0] dividend,
    input  wire logic [udiv_pkg::NUM_BITS-1:0] divisor,
    input  wire udiv_pkg::udiv_cmd_t         cmd,
    output udiv_pkg::udiv_sts_t              sts,
    output logic [udiv_pkg::NUM_BITS-1:0]    quotient,
    output logic [udiv_pkg::NUM_BITS-1:0]    remainder,
    output logic                             dbz
);

    // num_reg starts as the dividend; quotient bits fill in from the bottom
    logic [udiv_pkg::NUM_BITS-1:0] num_reg, num_next;
    logic [udiv_pkg::NUM_BITS-1:0] den_reg, den_next;
    logic [udiv_pkg::NUM_BITS-1:0] rem_reg, rem_next;
    logic                          dbz_reg, dbz_next;
    logic [udiv_pkg::NUM_BITS-1:0] quo_out_reg, quo_out_next;
    logic [udiv_pkg::NUM_BITS-1:0] rem_out_reg, rem_out_next;
    logic                          dbz_out_reg, dbz_out_next;

    logic                          over;
    logic [udiv_pkg::NUM_BITS-1:0] shifted;
    logic [udiv_pkg::NUM_BITS:0]   diff;
    logic                          fits;

    always_comb
    begin
        over    = rem_reg[udiv_pkg::NUM_BITS-1];
        shifted = {rem_reg[udiv_pkg::NUM_BITS-2:0], num_reg[udiv_pkg::NUM_BITS-1]};
        diff    = {1'b0, shifted} - {1'b0, den_reg};
        fits    = over | ~diff[udiv_pkg::NUM_BITS];

        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        dbz_next     = dbz_reg;
        quo_out_next = quo_out_reg;
        rem_out_next = rem_out_reg;
        dbz_out_next = dbz_out_reg;

        if (cmd.load)
        begin
            num_next = dividend;
            den_next = divisor;
            rem_next = '0;
            dbz_next = (divisor == '0);
        end
        else if (cmd.step)
        begin
            num_next = {num_reg[udiv_pkg::NUM_BITS-2:0], fits};
            rem_next = fits ? diff[udiv_pkg::NUM_BITS-1:0] : shifted;
        end

        if (cmd.capture)
        begin
            // zero divisor: steps were skipped, num_reg still holds the dividend
            quo_out_next = dbz_reg ? '0 : num_reg;
            rem_out_next = dbz_reg ? num_reg : rem_reg;
            dbz_out_next = dbz_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        dbz_reg     <= dbz_next;
        quo_out_reg <= quo_out_next;
        rem_out_reg <= rem_out_next;
        dbz_out_reg <= dbz_out_next;
    end

    assign sts.dbz   = dbz_reg;
    assign quotient  = quo_out_reg;
    assign remainder = rem_out_reg;
    assign dbz       = dbz_out_reg;

endmodule

`default_nettype wire

>>> rtl/core/udiv_ctrl.sv
// Divider controller: request handshake, step counter and output valid.
`default_nettype none

module udiv_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire udiv_pkg::udiv_sts_t sts,
    output udiv_pkg::udiv_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [udiv_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       slot_free;
    logic                       last_step;

    always_comb
    begin
        slot_free = ~out_valid_reg | out_ready;
        last_step = (cnt_reg == udiv_pkg::CNT_W'(udiv_pkg::NUM_BITS - 1));

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // skip the long division when the divisor is zero
                if (sts.dbz)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (last_step)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/uint256_divider.sv
// Top level of the 256-bit unsigned divider (restoring long division).
// Operands are loaded, then one quotient bit per cycle is produced through a single
// 256-bit subtract-and-compare stage, then the result is captured; a zero divisor
// skips the steps. A new request is taken only once the last one is captured, and
// a finished result waits in the output register while the next request is taken.
// Reset: rst_n asynchronous, active low; clears controller state and out_valid.
`default_nettype none
`include "uint256_divider_defines.svh"

module uint256_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [udiv_pkg::LIMB_W-1:0] dividend_w3,
    input  wire logic [udiv_pkg::LIMB_W-1:0] dividend_w2,
    input  wire logic [udiv_pkg::LIMB_W-1:0] dividend_w1,
    input  wire logic [udiv_pkg::LIMB_W-1:0] dividend_w0,
    input  wire logic [udiv_pkg::LIMB_W-1:0] divisor_w3,
    input  wire logic [udiv_pkg::LIMB_W-1:0] divisor_w2,
    input  wire logic [udiv_pkg::LIMB_W-1:0] divisor_w1,
    input  wire logic [udiv_pkg::LIMB_W-1:0] divisor_w0,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [udiv_pkg::LIMB_W-1:0]      quotient_w3,
    output logic [udiv_pkg::LIMB_W-1:0]      quotient_w2,
    output logic [udiv_pkg::LIMB_W-1:0]      quotient_w1,
    output logic [udiv_pkg::LIMB_W-1:0]      quotient_w0,
    output logic [udiv_pkg::LIMB_W-1:0]      remainder_w3,
    output logic [udiv_pkg::LIMB_W-1:0]      remainder_w2,
    output logic [udiv_pkg::LIMB_W-1:0]      remainder_w1,
    output logic [udiv_pkg::LIMB_W-1:0]      remainder_w0,
    output logic                             divide_by_zero
);

    udiv_pkg::udiv_cmd_t           cmd;
    udiv_pkg::udiv_sts_t           sts;
    logic [udiv_pkg::NUM_BITS-1:0] dividend;
    logic [udiv_pkg::NUM_BITS-1:0] divisor;
    logic [udiv_pkg::NUM_BITS-1:0] quotient;
    logic [udiv_pkg::NUM_BITS-1:0] remainder;

    assign dividend = {dividend_w3, dividend_w2, dividend_w1, dividend_w0};
    assign divisor  = {divisor_w3, divisor_w2, divisor_w1, divisor_w0};

    udiv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    udiv_datapath u_datapath (
        .clk       (clk),
        .dividend  (dividend),
        .divisor   (divisor),
        .cmd       (cmd),
        .sts       (sts),
        .quotient  (quotient),
        .remainder (remainder),
        .dbz       (divide_by_zero)
    );

    assign quotient_w3  = quotient[4*udiv_pkg::LIMB_W-1:3*udiv_pkg::LIMB_W];
    assign quotient_w2  = quotient[3*udiv_pkg::LIMB_W-1:2*udiv_pkg::LIMB_W];
    assign quotient_w1  = quotient[2*udiv_pkg::LIMB_W-1:udiv_pkg::LIMB_W];
    assign quotient_w0  = quotient[udiv_pkg::LIMB_W-1:0];
    assign remainder_w3 = remainder[4*udiv_pkg::LIMB_W-1:3*udiv_pkg::LIMB_W];
    assign remainder_w2 = remainder[3*udiv_pkg::LIMB_W-1:2*udiv_pkg::LIMB_W];
    assign remainder_w1 = remainder[2*udiv_pkg::LIMB_W-1:udiv_pkg::LIMB_W];
    assign remainder_w0 = remainder[udiv_pkg::LIMB_W-1:0];

    `UDIV_ASSERT_SAME(a_dbz_zero_quotient, out_valid && divide_by_zero,
                      quotient == '0, "divide by zero with nonzero quotient")
    `UDIV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                      "request taken while busy")
    `UDIV_ASSERT_NEXT(a_capture_sets_valid, cmd.capture, out_valid,
                      "captured result not presented")
    `UDIV_ASSERT_SAME(a_no_step_on_load, cmd.load, !cmd.step && !cmd.capture,
                      "conflicting datapath commands")

endmodule

`default_nettype wire
